// ===== src/barycentric_triangle_raster_defines.svh =====
// Assertion macros for the triangle raster block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BARYCENTRIC_TRIANGLE_RASTER_DEFINES_SVH
`define BARYCENTRIC_TRIANGLE_RASTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btr assertion failed");
`define BTR_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("btr assertion failed");
`else
`define BTR_ASSERT(lbl, prop)
`define BTR_ASSERT_NR(lbl, prop)
`endif
`endif

// ===== src/btr_pkg.sv =====
// Package for the triangle raster block: sequencer states and constants.
// No dependencies.
package btr_pkg;
  localparam int unsigned FrameWidthDefault  = 64;
  localparam int unsigned FrameHeightDefault = 64;

  localparam logic ActionDraw = 1'b0;
  localparam logic ActionRead = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SETUP,
    S_AREA,
    S_SCAN,
    S_MAC,
    S_DIV,
    S_WRITE
  } state_e;
endpackage

// ===== src/barycentric_triangle_raster.sv =====
// Barycentric triangle raster with on-chip grey frame store.
// Depends on btr_pkg and barycentric_triangle_raster_defines.svh.
//
//  channel | handshake              | payload
//  --------+------------------------+-----------------------------------------
//  in      | start_i & !busy_o      | action_i, vertex_*_i, read_column/row_i
//  result  | done_o (one cycle)     | pixel_value_o, culled_o, pixels_written_o
//
// After reset a clearing pass writes zero to each of FRAME_WIDTH*FRAME_HEIGHT
// entries, one per cycle; busy_o is high throughout.
// Read: one registered frame-store lookup. Draw: edge setup, then per box pixel a
// scan step, plus for a covered in-frame pixel 3 MAC steps, 8 divide steps and a write,
// all on one shared multiplier and a one-bit-a-step divider.
// The result beat is not stalled; busy_o stays high until it is issued.
`include "barycentric_triangle_raster_defines.svh"
module barycentric_triangle_raster #(
  parameter int unsigned FRAME_WIDTH  = btr_pkg::FrameWidthDefault,
  parameter int unsigned FRAME_HEIGHT = btr_pkg::FrameHeightDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        action_i,
  input  logic [5:0]  vertex_a_x_i,
  input  logic [5:0]  vertex_a_y_i,
  input  logic [7:0]  vertex_a_depth_i,
  input  logic [5:0]  vertex_b_x_i,
  input  logic [5:0]  vertex_b_y_i,
  input  logic [7:0]  vertex_b_depth_i,
  input  logic [5:0]  vertex_c_x_i,
  input  logic [5:0]  vertex_c_y_i,
  input  logic [7:0]  vertex_c_depth_i,
  input  logic [5:0]  read_column_i,
  input  logic [5:0]  read_row_i,
  output logic        done_o,
  output logic [7:0]  pixel_value_o,
  output logic        culled_o,
  output logic [12:0] pixels_written_o
);
  localparam int unsigned Depth = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = $clog2(Depth);

  btr_pkg::state_e state_q, state_d;

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;
  logic       mem_we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  logic [AW-1:0] clr_q, clr_d;
  logic [5:0] vx_q [3];
  logic [5:0] vy_q [3];
  logic [7:0] vz_q [3];
  logic       rd_ok_q, rd_ok_d;
  logic [1:0] step_q, step_d;
  logic [1:0] edge_q, edge_d;
  logic [2:0] bit_q, bit_d;
  logic signed [24:0] acc_q, acc_d;
  logic signed [15:0] e_q [3];
  logic signed [15:0] e_d [3];
  logic signed [15:0] ecol_q [3];
  logic signed [15:0] ecol_d [3];
  logic [12:0] area_q, area_d;
  logic [12:0] rem_q, rem_d;
  logic [7:0]  quo_q, quo_d;
  logic [5:0]  x_q, x_d, y_q, y_d;
  logic [12:0] cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [7:0]  pix_q, pix_d;
  logic        cul_q, cul_d;

  logic signed [7:0] ca [3];
  logic signed [7:0] cb [3];
  logic [5:0] x0, x1, y0, y1;
  logic [1:0] pi, qi;
  logic signed [15:0] mul_a;
  logic signed [8:0]  mul_b;
  logic signed [24:0] prod;
  logic signed [15:0] area_sum;
  logic [13:0] trial;
  logic        trial_ge;
  logic        covered, in_frame, accept;

  assign accept = start_i && (state_q == btr_pkg::S_IDLE);
  assign busy_o = (state_q != btr_pkg::S_IDLE);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ca[k] = $signed({2'b0, vy_q[(k + 1) % 3]}) - $signed({2'b0, vy_q[(k + 2) % 3]});
      cb[k] = $signed({2'b0, vx_q[(k + 2) % 3]}) - $signed({2'b0, vx_q[(k + 1) % 3]});
    end
  end

  always_comb begin
    x0 = (vx_q[0] < vx_q[1]) ? vx_q[0] : vx_q[1];
    x0 = (vx_q[2] < x0) ? vx_q[2] : x0;
    x1 = (vx_q[0] > vx_q[1]) ? vx_q[0] : vx_q[1];
    x1 = (vx_q[2] > x1) ? vx_q[2] : x1;
    y0 = (vy_q[0] < vy_q[1]) ? vy_q[0] : vy_q[1];
    y0 = (vy_q[2] < y0) ? vy_q[2] : y0;
    y1 = (vy_q[0] > vy_q[1]) ? vy_q[0] : vy_q[1];
    y1 = (vy_q[2] > y1) ? vy_q[2] : y1;
  end

  always_comb begin
    case (edge_q)
      2'd0:    begin pi = 2'd1; qi = 2'd2; end
      2'd1:    begin pi = 2'd2; qi = 2'd0; end
      default: begin pi = 2'd0; qi = 2'd1; end
    endcase
  end

  // shared multiplier: edge setup terms, then depth weighting per pixel
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == btr_pkg::S_SETUP) begin
      case (step_q)
        2'd0: begin
          mul_a = $signed({10'b0, vx_q[pi]});
          mul_b = $signed({3'b0, vy_q[qi]});
        end
        2'd1: begin
          mul_a = $signed({10'b0, vy_q[pi]});
          mul_b = -$signed({3'b0, vx_q[qi]});
        end
        2'd2: begin
          mul_a = 16'(ca[edge_q]);
          mul_b = $signed({3'b0, x0});
        end
        default: begin
          mul_a = 16'(cb[edge_q]);
          mul_b = $signed({3'b0, y0});
        end
      endcase
    end else if (state_q == btr_pkg::S_MAC) begin
      mul_a = e_q[step_q];
      mul_b = $signed({1'b0, vz_q[step_q]});
    end
  end
  assign prod = mul_a * mul_b;

  assign area_sum = e_q[0] + e_q[1] + e_q[2];
  assign trial    = {rem_q, quo_q[7]};
  assign trial_ge = (trial >= {1'b0, area_q});
  assign covered  = !e_q[0][15] && !e_q[1][15] && !e_q[2][15];
  assign in_frame = (32'(x_q) < FRAME_WIDTH) && (32'(y_q) < FRAME_HEIGHT);

  always_comb begin
    state_d = state_q;
    case (state_q)
      btr_pkg::S_CLEAR: if (32'(clr_q) == Depth - 1) state_d = btr_pkg::S_IDLE;
      btr_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (action_i == btr_pkg::ActionRead) ? btr_pkg::S_READ : btr_pkg::S_SETUP;
        end
      end
      btr_pkg::S_READ:  state_d = btr_pkg::S_IDLE;
      btr_pkg::S_SETUP: if (step_q == 2'd3 && edge_q == 2'd2) state_d = btr_pkg::S_AREA;
      btr_pkg::S_AREA:  state_d = (area_sum < 16'sd2) ? btr_pkg::S_IDLE : btr_pkg::S_SCAN;
      btr_pkg::S_SCAN: begin
        if (covered && in_frame) state_d = btr_pkg::S_MAC;
        else if (x_q == x1 && y_q == y1) state_d = btr_pkg::S_IDLE;
      end
      btr_pkg::S_MAC:   if (step_q == 2'd2) state_d = btr_pkg::S_DIV;
      btr_pkg::S_DIV:   if (bit_q == 3'd7) state_d = btr_pkg::S_WRITE;
      btr_pkg::S_WRITE: begin
        state_d = (x_q == x1 && y_q == y1) ? btr_pkg::S_IDLE : btr_pkg::S_SCAN;
      end
      default: state_d = btr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    clr_d   = clr_q;
    rd_ok_d = rd_ok_q;
    step_d  = step_q;
    edge_d  = edge_q;
    bit_d   = bit_q;
    acc_d   = acc_q;
    e_d     = e_q;
    ecol_d  = ecol_q;
    area_d  = area_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    x_d     = x_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    pix_d   = pix_q;
    cul_d   = cul_q;
    mem_we  = 1'b0;
    waddr   = AW'(32'(y_q) * FRAME_WIDTH + 32'(x_q));
    wdata   = quo_q;
    case (state_q)
      btr_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + 1'b1;
      end
      btr_pkg::S_IDLE: begin
        rd_ok_d = (32'(read_column_i) < FRAME_WIDTH) && (32'(read_row_i) < FRAME_HEIGHT);
        step_d  = '0;
        edge_d  = '0;
        acc_d   = '0;
        cnt_d   = '0;
      end
      btr_pkg::S_READ: begin
        done_d = 1'b1;
        pix_d  = rd_ok_q ? rdata_q : 8'd0;
        cul_d  = 1'b0;
      end
      btr_pkg::S_SETUP: begin
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) begin
          e_d[edge_q]    = 16'(acc_q + prod);
          ecol_d[edge_q] = 16'(acc_q + prod);
          acc_d          = '0;
          edge_d         = edge_q + 1'b1;
        end else begin
          acc_d = acc_q + prod;
        end
      end
      btr_pkg::S_AREA: begin
        area_d = area_sum[12:0];
        x_d    = x0;
        y_d    = y0;
        step_d = '0;
        if (area_sum < 16'sd2) begin
          done_d = 1'b1;
          pix_d  = '0;
          cul_d  = 1'b1;
        end
      end
      btr_pkg::S_MAC: begin
        step_d = step_q + 1'b1;
        acc_d  = acc_q + prod;
        if (step_q == 2'd2) begin
          rem_d = 13'((acc_q + prod) >>> 8);
          quo_d = 8'(acc_q + prod);
          bit_d = '0;
        end
      end
      btr_pkg::S_DIV: begin
        bit_d = bit_q + 1'b1;
        rem_d = trial_ge ? 13'(trial - {1'b0, area_q}) : trial[12:0];
        quo_d = {quo_q[6:0], trial_ge};
      end
      default: ;
    endcase

    if (state_q == btr_pkg::S_WRITE) begin
      mem_we = 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end

    // advance the scan: y inner, x outer
    if ((state_q == btr_pkg::S_SCAN && !(covered && in_frame)) ||
        state_q == btr_pkg::S_WRITE) begin
      step_d = '0;
      acc_d  = '0;
      if (y_q == y1) begin
        if (x_q == x1) begin
          done_d = 1'b1;
          pix_d  = '0;
          cul_d  = 1'b0;
        end else begin
          x_d = x_q + 1'b1;
          y_d = y0;
          for (int k = 0; k < 3; k++) begin
            ecol_d[k] = ecol_q[k] + 16'(ca[k]);
            e_d[k]    = ecol_q[k] + 16'(ca[k]);
          end
        end
      end else begin
        y_d = y_q + 1'b1;
        for (int k = 0; k < 3; k++) e_d[k] = e_q[k] + 16'(cb[k]);
      end
    end
    if (state_q == btr_pkg::S_WRITE && x_q == x1 && y_q == y1) cnt_d = cnt_q + 1'b1;
  end

  assign raddr = AW'(32'(read_row_i) * FRAME_WIDTH + 32'(read_column_i));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btr_pkg::S_CLEAR;
      clr_q   <= '0;
      step_q  <= '0;
      edge_q  <= '0;
      bit_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      step_q  <= step_d;
      edge_q  <= edge_d;
      bit_q   <= bit_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q[0] <= vertex_a_x_i;
      vy_q[0] <= vertex_a_y_i;
      vz_q[0] <= vertex_a_depth_i;
      vx_q[1] <= vertex_b_x_i;
      vy_q[1] <= vertex_b_y_i;
      vz_q[1] <= vertex_b_depth_i;
      vx_q[2] <= vertex_c_x_i;
      vy_q[2] <= vertex_c_y_i;
      vz_q[2] <= vertex_c_depth_i;
    end
    rd_ok_q <= rd_ok_d;
    acc_q   <= acc_d;
    e_q     <= e_d;
    ecol_q  <= ecol_d;
    area_q  <= area_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    x_q     <= x_d;
    y_q     <= y_d;
    pix_q   <= pix_d;
    cul_q   <= cul_d;
  end

  assign done_o           = done_q;
  assign pixel_value_o    = pix_q;
  assign culled_o         = cul_q;
  assign pixels_written_o = cul_q ? 13'd0 : (pix_q != 8'd0 ? 13'd0 : cnt_q);

  `BTR_ASSERT(a_write_states, mem_we |-> (state_q == btr_pkg::S_WRITE || state_q == btr_pkg::S_CLEAR))
  `BTR_ASSERT(a_culled_no_pixels, (done_o && culled_o) |-> (pixels_written_o == 13'd0))
  `BTR_ASSERT(a_accept_busy, accept |=> busy_o)
  `BTR_ASSERT(a_count_bound, done_o |-> (pixels_written_o <= 13'd4096))
endmodule
